// ----- rtl/kvt_pkg.sv -----
package kvt_pkg;

    // widths of the request and result fields on the channels
    localparam int WORD_BITS = 64;
    localparam int MODE_BITS = 2;
    localparam int STATUS_BITS = 2;

    // request modes
    localparam logic [MODE_BITS-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_DEL   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_GET   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_OTHER = 2'd3;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_INVALID   = 2'd3;

    // search token handed from cell to cell
    typedef struct packed {
        logic active;
        logic hit;
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/kvt_req_if.sv -----
interface kvt_req_if;
    logic                                valid;
    logic                                ready;
    logic [kvt_pkg::MODE_BITS-1:0]       mode;
    logic [kvt_pkg::WORD_BITS-1:0]       lookup_key;
    logic [kvt_pkg::WORD_BITS-1:0]       entry_value;

    modport source (
        output valid,
        output mode,
        output lookup_key,
        output entry_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  lookup_key,
        input  entry_value,
        output ready
    );
endinterface

// ----- rtl/kvt_rsp_if.sv -----
interface kvt_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [kvt_pkg::STATUS_BITS-1:0]     status;
    logic [kvt_pkg::WORD_BITS-1:0]       found_value;

    modport source (
        output valid,
        output status,
        output found_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  found_value,
        output ready
    );
endinterface

// ----- rtl/kvt_cell.sv -----
module kvt_cell #(
    parameter int INDEX       = 0,
    parameter int MAX_ENTRIES = 128,
    parameter int KEY_BITS    = 64,
    parameter int VALUE_BITS  = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request broadcast from the controller
    input  logic [kvt_pkg::MODE_BITS-1:0]    req_mode,
    input  logic [KEY_BITS-1:0]              req_key,
    input  logic [VALUE_BITS-1:0]            req_value,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0] count,
    // token from the left neighbor, registered token to the right
    input  kvt_pkg::tok_t                    tok_in,
    input  logic [VALUE_BITS-1:0]            found_in,
    output kvt_pkg::tok_t                    tok_out,
    output logic [VALUE_BITS-1:0]            found_out,
    // entry moving left during a delete
    input  logic                             shift_in,
    input  logic [KEY_BITS-1:0]              nb_key_in,
    input  logic [VALUE_BITS-1:0]            nb_value_in,
    output logic                             shift_out,
    output logic [KEY_BITS-1:0]              key_out,
    output logic [VALUE_BITS-1:0]            value_out
);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    kvt_pkg::tok_t         tok_reg;
    kvt_pkg::tok_t         tok_next;
    logic [VALUE_BITS-1:0] found_reg;
    logic [VALUE_BITS-1:0] found_next;

    logic occupied;
    logic match;
    logic append;

    assign occupied  = (IDX < count);
    assign match     = tok_in.active && occupied && (key_reg == req_key);
    // first free slot, reached with no earlier hit
    assign append    = tok_in.active && (req_mode == kvt_pkg::MODE_PUT)
                       && !tok_in.hit && (IDX == count);
    // every slot past a deleted one moves one step left
    assign shift_out = tok_in.active && (req_mode == kvt_pkg::MODE_DEL) && tok_in.hit;
    assign key_out   = key_reg;
    assign value_out = value_reg;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        priority if (shift_in)
        begin
            key_next   = nb_key_in;
            value_next = nb_value_in;
        end
        else if (append)
        begin
            key_next   = req_key;
            value_next = req_value;
        end
        else if (match && (req_mode == kvt_pkg::MODE_PUT))
        begin
            value_next = req_value;
        end
        else
        begin
            key_next   = key_reg;
            value_next = value_reg;
        end
    end

    always_comb
    begin
        tok_next.active = tok_in.active;
        tok_next.hit    = tok_in.hit || match;
        found_next      = match ? value_reg : found_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        found_reg <= found_next;
    end

    assign tok_out   = tok_reg;
    assign found_out = found_reg;

endmodule

// ----- rtl/key_value_table_unit.sv -----
// Key/value table of up to MAX_ENTRIES pairs, held in a row of identical cells
// with one entry each. Slots 0 .. count-1 are occupied; keys are unique. Each
// put, delete or get sends a search token down the row, one cell per cycle;
// every cell compares its key with the request, a put of a new key lands in
// the first free cell, and after a delete hit each later cell hands its entry
// to its left neighbor so the row stays packed. The token always walks the
// whole row before the next request is taken; a request of the unused mode
// skips the search. The result sits in an output register, so a new request
// is taken while it waits. Bits of key and value above KEY_BITS and
// VALUE_BITS are dropped. Cell contents are undefined after reset; only
// occupied cells are ever read.
module key_value_table_unit #(
    parameter int MAX_ENTRIES = 128,
    parameter int KEY_BITS    = 64,
    parameter int VALUE_BITS  = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    kvt_req_if.sink    req,
    kvt_rsp_if.source  rsp
);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // control state
    kvt_pkg::state_t                   state_reg;
    kvt_pkg::state_t                   state_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              start_reg;
    logic                              out_valid_reg;

    // held request
    logic [kvt_pkg::MODE_BITS-1:0]     mode_reg;
    logic [KEY_BITS-1:0]               key_reg;
    logic [VALUE_BITS-1:0]             value_reg;

    // search outcome from the end of the row
    logic                              hit_reg;
    logic [VALUE_BITS-1:0]             found_reg;

    // result register
    logic [kvt_pkg::STATUS_BITS-1:0]   out_status_reg;
    logic [kvt_pkg::STATUS_BITS-1:0]   out_status_next;
    logic [kvt_pkg::WORD_BITS-1:0]     out_value_reg;
    logic [kvt_pkg::WORD_BITS-1:0]     out_value_next;

    logic req_xfer;
    logic load_out;
    logic chain_done;

    // links of the cell row: tok and found entry i feeds cell i, shift/nkey/nval entry i comes from cell i
    kvt_pkg::tok_t         tok   [0:MAX_ENTRIES];
    logic [VALUE_BITS-1:0] found [0:MAX_ENTRIES];
    logic                  shift [0:MAX_ENTRIES];
    logic [KEY_BITS-1:0]   nkey  [0:MAX_ENTRIES];
    logic [VALUE_BITS-1:0] nval  [0:MAX_ENTRIES];

    // requests are taken only in the idle state, not during a search or while a result waits to load
    assign req.ready  = (state_reg == kvt_pkg::ST_IDLE);
    assign req_xfer   = req.valid && req.ready;
    assign chain_done = tok[MAX_ENTRIES].active;

    // head of the row: token injected in the cycle after the transfer
    assign tok[0].active = start_reg;
    assign tok[0].hit    = 1'b0;
    assign found[0]      = '0;

    // tail of the row: nothing to the right
    assign shift[MAX_ENTRIES] = 1'b0;
    assign nkey[MAX_ENTRIES]  = '0;
    assign nval[MAX_ENTRIES]  = '0;

    generate
        for (genvar i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            kvt_cell #(
                .INDEX       (i),
                .MAX_ENTRIES (MAX_ENTRIES),
                .KEY_BITS    (KEY_BITS),
                .VALUE_BITS  (VALUE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .req_mode    (mode_reg),
                .req_key     (key_reg),
                .req_value   (value_reg),
                .count       (count_reg),
                .tok_in      (tok[i]),
                .found_in    (found[i]),
                .tok_out     (tok[i+1]),
                .found_out   (found[i+1]),
                .shift_in    (shift[i+1]),
                .nb_key_in   (nkey[i+1]),
                .nb_value_in (nval[i+1]),
                .shift_out   (shift[i]),
                .key_out     (nkey[i]),
                .value_out   (nval[i])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kvt_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    // unused mode skips the search
                    if (req.mode == kvt_pkg::MODE_OTHER)
                        state_next = kvt_pkg::ST_FINISH;
                    else
                        state_next = kvt_pkg::ST_SEARCH;
                end
            end
            kvt_pkg::ST_SEARCH:
            begin
                if (chain_done)
                    state_next = kvt_pkg::ST_FINISH;
            end
            kvt_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = kvt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kvt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: result and count update, applied when the result register frees
    always_comb
    begin
        load_out        = (state_reg == kvt_pkg::ST_FINISH) && (!out_valid_reg || rsp.ready);
        count_next      = count_reg;
        out_status_next = kvt_pkg::STATUS_INVALID;
        out_value_next  = '0;
        unique case (mode_reg)
            kvt_pkg::MODE_PUT:
            begin
                if (hit_reg)
                begin
                    out_status_next = kvt_pkg::STATUS_OK;
                end
                else if (count_reg == CNT_W'(MAX_ENTRIES))
                begin
                    // only a new key is refused when full
                    out_status_next = kvt_pkg::STATUS_FULL;
                end
                else
                begin
                    out_status_next = kvt_pkg::STATUS_OK;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            kvt_pkg::MODE_DEL:
            begin
                if (hit_reg)
                begin
                    out_status_next = kvt_pkg::STATUS_OK;
                    count_next      = count_reg - CNT_W'(1);
                end
                else
                begin
                    out_status_next = kvt_pkg::STATUS_NOT_FOUND;
                end
            end
            kvt_pkg::MODE_GET:
            begin
                if (hit_reg)
                begin
                    out_status_next = kvt_pkg::STATUS_OK;
                    out_value_next  = kvt_pkg::WORD_BITS'(found_reg);
                end
                else
                begin
                    out_status_next = kvt_pkg::STATUS_NOT_FOUND;
                end
            end
            kvt_pkg::MODE_OTHER:
            begin
                out_status_next = kvt_pkg::STATUS_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvt_pkg::ST_IDLE;
            count_reg     <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= req_xfer && (req.mode != kvt_pkg::MODE_OTHER);
            if (load_out)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            mode_reg  <= req.mode;
            key_reg   <= req.lookup_key[KEY_BITS-1:0];
            value_reg <= req.entry_value[VALUE_BITS-1:0];
        end
        if (chain_done)
        begin
            hit_reg   <= tok[MAX_ENTRIES].hit;
            found_reg <= found[MAX_ENTRIES];
        end
        if (load_out)
        begin
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_value = out_value_reg;

endmodule

// ----- tb/key_value_table_unit_test.sv -----
module key_value_table_unit_test;

    // table geometry, kept at the block defaults
    localparam int TABLE_DEPTH = 128;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 64;

    // time for a full search: every cell of the row plus the handoff around it
    localparam int SEARCH_CYCLES = TABLE_DEPTH + 3;
    // quiet time after the last reply, so a stray extra reply still shows up
    localparam int TAIL_CYCLES   = SEARCH_CYCLES + 30;
    // roughly 450 requests plus one long hold-off,
    // taken several times over
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLDOFF_CYCLES = 1200;

    localparam logic [kvt_pkg::WORD_BITS-1:0] KEY_MASK =
        {kvt_pkg::WORD_BITS{1'b1}} >> (kvt_pkg::WORD_BITS - KEY_BITS);
    localparam logic [kvt_pkg::WORD_BITS-1:0] VALUE_MASK =
        {kvt_pkg::WORD_BITS{1'b1}} >> (kvt_pkg::WORD_BITS - VALUE_BITS);
    localparam logic [kvt_pkg::WORD_BITS-1:0] ALL_ONES = {kvt_pkg::WORD_BITS{1'b1}};
    localparam logic [kvt_pkg::WORD_BITS-1:0] ALT_A    = {(kvt_pkg::WORD_BITS / 2){2'b10}};
    localparam logic [kvt_pkg::WORD_BITS-1:0] ALT_5    = {(kvt_pkg::WORD_BITS / 2){2'b01}};

    // one reply as seen on the response channel
    typedef struct packed {
        logic [kvt_pkg::STATUS_BITS-1:0] status;
        logic [kvt_pkg::WORD_BITS-1:0]   found_value;
    } reply_t;

    logic clk;
    logic rst_n;

    kvt_req_if req ();
    kvt_rsp_if rsp ();

    key_value_table_unit #(
        .MAX_ENTRIES (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow copy of the table, updated in request order at each accepted transfer
    logic [kvt_pkg::WORD_BITS-1:0] shadow_keys [TABLE_DEPTH];
    logic [kvt_pkg::WORD_BITS-1:0] shadow_values [TABLE_DEPTH];
    int                            shadow_count;

    // replies still owed by the block, oldest first
    reply_t expected_replies [$];

    int  mismatch_count;
    int  cycle_count;
    int  rsp_holdoff_cycles;
    bit  fast_sender;
    bit  fast_receiver;

    // clock, period 20
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // run-away guard: a hung handshake or a lost reply ends up here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // slot holding the key, or shadow_count when absent
    function automatic int shadow_slot(input logic [kvt_pkg::WORD_BITS-1:0] key);
        int slot;
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] != key)
            slot++;
        return slot;
    endfunction

    // applies one request to the shadow table and returns the reply it owes
    function automatic reply_t update_shadow_table(
        input logic [kvt_pkg::MODE_BITS-1:0] mode,
        input logic [kvt_pkg::WORD_BITS-1:0] raw_key,
        input logic [kvt_pkg::WORD_BITS-1:0] raw_value
    );
        reply_t                        reply;
        logic [kvt_pkg::WORD_BITS-1:0] key;
        logic [kvt_pkg::WORD_BITS-1:0] value;
        int                            slot;
        key = raw_key & KEY_MASK;
        value = raw_value & VALUE_MASK;
        reply.status = kvt_pkg::STATUS_INVALID;
        reply.found_value = '0;
        slot = shadow_slot(key);
        case (mode)
            kvt_pkg::MODE_PUT:
            begin
                if (slot < shadow_count)
                begin
                    // present key: overwrite, even when the table is full
                    shadow_values[slot] = value;
                    reply.status = kvt_pkg::STATUS_OK;
                end
                else if (shadow_count >= TABLE_DEPTH)
                begin
                    reply.status = kvt_pkg::STATUS_FULL;
                end
                else
                begin
                    shadow_keys[shadow_count] = key;
                    shadow_values[shadow_count] = value;
                    shadow_count++;
                    reply.status = kvt_pkg::STATUS_OK;
                end
            end
            kvt_pkg::MODE_DEL:
            begin
                if (slot < shadow_count)
                begin
                    // last entry moves into the hole, nothing moves when the hole is last
                    if (slot != shadow_count - 1)
                    begin
                        shadow_keys[slot] = shadow_keys[shadow_count - 1];
                        shadow_values[slot] = shadow_values[shadow_count - 1];
                    end
                    shadow_count--;
                    reply.status = kvt_pkg::STATUS_OK;
                end
                else
                begin
                    reply.status = kvt_pkg::STATUS_NOT_FOUND;
                end
            end
            kvt_pkg::MODE_GET:
            begin
                if (slot < shadow_count)
                begin
                    reply.found_value = shadow_values[slot];
                    reply.status = kvt_pkg::STATUS_OK;
                end
                else
                begin
                    reply.status = kvt_pkg::STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                reply.status = kvt_pkg::STATUS_INVALID;
            end
        endcase
        return reply;
    endfunction

    function automatic logic [kvt_pkg::WORD_BITS-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // a key not in the table right now
    function automatic logic [kvt_pkg::WORD_BITS-1:0] fresh_key();
        logic [kvt_pkg::WORD_BITS-1:0] key;
        do
            key = random_word();
        while (shadow_slot(key) < shadow_count);
        return key;
    endfunction

    // a key that is in the table; caller makes sure it is not empty
    function automatic logic [kvt_pkg::WORD_BITS-1:0] stored_key();
        return shadow_keys[$urandom_range(0, shadow_count - 1)];
    endfunction

    // mostly hits, some one-bit near misses, the rest random
    function automatic logic [kvt_pkg::WORD_BITS-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (shadow_count > 0 && roll < 65)
            return stored_key();
        if (shadow_count > 0 && roll < 80)
            return stored_key() ^ (64'd1 << $urandom_range(0, kvt_pkg::WORD_BITS - 1));
        return random_word();
    endfunction

    task automatic note_mismatch(
        input string                         field,
        input logic [kvt_pkg::WORD_BITS-1:0] want,
        input logic [kvt_pkg::WORD_BITS-1:0] seen
    );
        mismatch_count++;
        $display("%0t: %s differs, expected %h, got %h", $time, field, want, seen);
    endtask

    // one request transfer; returns at the edge that accepted it with valid still high,
    // so a back-to-back request just replaces the payload
    task automatic send_request(
        input logic [kvt_pkg::MODE_BITS-1:0] mode,
        input logic [kvt_pkg::WORD_BITS-1:0] key,
        input logic [kvt_pkg::WORD_BITS-1:0] value
    );
        int gap;
        gap = fast_sender ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= mode;
        req.lookup_key  <= key;
        req.entry_value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_replies.push_back(update_shadow_table(mode, key, value));
    endtask

    // drop valid and wait until every owed reply has come back
    task automatic drain_requests();
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // response side: per-transfer random stall, no-stall stretches, and
    // the long hold-off that backs the block up
    initial
    begin : reply_sink
        int stall;
        rsp.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rsp_holdoff_cycles > 0)
            begin
                rsp.ready <= 1'b0;
                while (rsp_holdoff_cycles > 0)
                begin
                    @(posedge clk);
                    rsp_holdoff_cycles--;
                end
            end
            stall = fast_receiver ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid && rsp_holdoff_cycles == 0)
                @(posedge clk);
        end
    end

    // compares every reply transfer against the oldest owed reply
    initial
    begin : reply_checker
        reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (expected_replies.size() == 0)
                begin
                    note_mismatch("reply with nothing owed", '0, rsp.found_value);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp.status !== want.status)
                        note_mismatch("status", kvt_pkg::WORD_BITS'(want.status),
                                      kvt_pkg::WORD_BITS'(rsp.status));
                    if (rsp.found_value !== want.found_value)
                        note_mismatch("found_value", want.found_value, rsp.found_value);
                end
            end
        end
    end

    // corner requests on a nearly empty table, ends empty again
    task automatic test_directed_corners();
        send_request(kvt_pkg::MODE_GET, '0, '0);                 // get on empty table
        send_request(kvt_pkg::MODE_DEL, ALL_ONES, '0);           // delete on empty table
        send_request(kvt_pkg::MODE_OTHER, ALL_ONES, ALL_ONES);   // unused mode
        send_request(kvt_pkg::MODE_PUT, '0, ALL_ONES);
        send_request(kvt_pkg::MODE_PUT, ALL_ONES, '0);
        send_request(kvt_pkg::MODE_PUT, ALT_A, ALT_5);
        send_request(kvt_pkg::MODE_GET, '0, ALL_ONES);
        send_request(kvt_pkg::MODE_GET, ALL_ONES, ALL_ONES);
        send_request(kvt_pkg::MODE_GET, ALT_A, '0);
        send_request(kvt_pkg::MODE_PUT, '0, 64'h0123_4567_89ab_cdef);    // overwrite
        send_request(kvt_pkg::MODE_GET, '0, '0);
        send_request(kvt_pkg::MODE_GET, ALT_5, '0);              // absent key
        send_request(kvt_pkg::MODE_DEL, '0, '0);                 // first slot, last entry moves in
        send_request(kvt_pkg::MODE_GET, ALT_A, '0);
        send_request(kvt_pkg::MODE_DEL, ALL_ONES, '0);           // hole is the last slot
        send_request(kvt_pkg::MODE_GET, ALL_ONES, '0);
        send_request(kvt_pkg::MODE_DEL, ALL_ONES, '0);
        send_request(kvt_pkg::MODE_OTHER, '0, '0);
        send_request(kvt_pkg::MODE_GET, ALT_A, ALT_A);
        send_request(kvt_pkg::MODE_DEL, ALT_A, '0);
        send_request(kvt_pkg::MODE_GET, ALT_A, '0);
        drain_requests();
    endtask

    // fill every slot, then check the full-table behavior
    task automatic test_fill_to_capacity();
        logic [kvt_pkg::WORD_BITS-1:0] key;
        while (shadow_count < TABLE_DEPTH)
            send_request(kvt_pkg::MODE_PUT, fresh_key(), random_word());
        send_request(kvt_pkg::MODE_PUT, fresh_key(), random_word());     // new key refused
        key = stored_key();
        send_request(kvt_pkg::MODE_PUT, key, random_word());             // present key still updates
        send_request(kvt_pkg::MODE_GET, key, '0);
        send_request(kvt_pkg::MODE_GET, shadow_keys[TABLE_DEPTH - 1], '0);
        send_request(kvt_pkg::MODE_DEL, fresh_key(), '0);
        send_request(kvt_pkg::MODE_DEL, stored_key(), '0);
        send_request(kvt_pkg::MODE_PUT, fresh_key(), random_word());     // room again
        send_request(kvt_pkg::MODE_PUT, fresh_key(), random_word());     // full again
        drain_requests();
    endtask

    // receiver stops for a long stretch while requests keep coming,
    // so the result register and then the request side back up
    task automatic test_reply_backpressure();
        int n;
        fast_sender = 1'b1;
        rsp_holdoff_cycles = HOLDOFF_CYCLES;
        for (n = 0; n < 8; n++)
            send_request(n % 3 == 0 ? kvt_pkg::MODE_PUT : kvt_pkg::MODE_GET,
                         pick_key(), random_word());
        fast_sender = 1'b0;
        drain_requests();
    endtask

    // weighted random mix; idling turns off on both sides for some stretches
    task automatic test_random_mix(input int count);
        int n;
        int roll;
        logic [kvt_pkg::MODE_BITS-1:0] mode;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                fast_sender = ((n / 40) % 3 == 1);
                fast_receiver = fast_sender;
            end
            roll = $urandom_range(0, 99);
            if (roll < 35)
                mode = kvt_pkg::MODE_PUT;
            else if (roll < 60)
                mode = kvt_pkg::MODE_DEL;
            else if (roll < 95)
                mode = kvt_pkg::MODE_GET;
            else
                mode = kvt_pkg::MODE_OTHER;
            // puts of new keys keep the table from draining
            if (mode == kvt_pkg::MODE_PUT && $urandom_range(0, 1) == 1)
                send_request(mode, fresh_key(), random_word());
            else
                send_request(mode, pick_key(), random_word());
        end
        fast_sender = 1'b0;
        fast_receiver = 1'b0;
        drain_requests();
    endtask

    // empty the table: deletes from anywhere and from the last slot, with gets between
    task automatic test_drain_table();
        int roll;
        while (shadow_count > 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                send_request(kvt_pkg::MODE_DEL, stored_key(), random_word());
            else if (roll < 80)
                send_request(kvt_pkg::MODE_DEL, shadow_keys[shadow_count - 1], random_word());
            else
                send_request(kvt_pkg::MODE_GET, stored_key(), random_word());
        end
        send_request(kvt_pkg::MODE_GET, random_word(), random_word());
        drain_requests();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.mode          <= kvt_pkg::MODE_PUT;
        req.lookup_key    <= '0;
        req.entry_value   <= '0;
        shadow_count       = 0;
        mismatch_count     = 0;
        cycle_count        = 0;
        rsp_holdoff_cycles = 0;
        fast_sender        = 1'b0;
        fast_receiver      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_fill_to_capacity();
        test_reply_backpressure();
        test_random_mix(120);
        test_drain_table();

        // any reply beyond the owed ones lands in the checker during this wait
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
